[rtl/s20_pkg.sv]
// Shared types and constants for the Salsa20 stream cipher block.
package s20_pkg;

    typedef logic [31:0] t_word;
    typedef logic [15:0][31:0] t_block;
    typedef logic [7:0][63:0] t_ks_rows;

    typedef struct packed {
        logic [63:0] text_in;
        logic [3:0]  bytes_in;
        logic        message_end;
    } t_in_item;

    typedef struct packed {
        logic [63:0] text_out;
        logic [3:0]  bytes_out;
    } t_out_item;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE      = 3'd4;

    // "expand 32-byte k" as four little-endian words.
    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    localparam logic [3:0] FULL_BYTES = 4'd8;

    typedef enum logic {
        ST_IDLE,
        ST_GEN
    } t_top_state;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_ADD
    } t_core_state;

endpackage

[rtl/salsa20_stream_cipher_top.sv]
// Salsa20 stream cipher top level: key registers, chunk sequencing and XOR.
// A chunk that needs a fresh keystream block waits while the core generates it:
// one round per cycle in the shared round unit, then the feed-forward add.
// Other chunks have their result registered in the cycle after the beat; one chunk
// per cycle then, while the output is not stalled. A full block serves eight chunks.
// Synchronous active-low reset clears key, nonce, counter and all control state.
module salsa20_stream_cipher_top #(
    parameter int unsigned ROUNDS = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  s20_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output s20_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [s20_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [63:0]                        i_cfg_data
);
    import s20_pkg::*;

    t_top_state  r_state, n_state;
    logic [63:0] r_key [4];
    logic [63:0] r_nonce;
    logic [63:0] r_counter;
    logic [2:0]  r_pos;
    logic        r_blk_ready;
    t_ks_rows    r_ks;
    t_in_item    r_item;
    t_out_item   r_out;
    logic        r_out_valid;

    logic        in_fire;
    logic        cfg_fire;
    logic        need_gen;
    logic        core_start;
    logic        core_done;
    t_block      core_block;
    t_block      init_words;
    t_ks_rows    new_rows;
    t_in_item    src;
    logic [3:0]  n_bytes;
    logic [3:0]  acc_bytes;
    logic [63:0] ks_row;
    logic [63:0] result;
    logic [2:0]  cur_pos;
    logic [2:0]  next_pos;
    logic        out_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign acc_bytes  = i_in_data.bytes_in[3] ? FULL_BYTES : i_in_data.bytes_in;
    assign need_gen   = (acc_bytes != 4'd0) && !r_blk_ready;
    assign core_start = in_fire && need_gen;

    always_comb begin
        init_words[0]  = SIGMA_0;
        init_words[1]  = r_key[0][31:0];
        init_words[2]  = r_key[0][63:32];
        init_words[3]  = r_key[1][31:0];
        init_words[4]  = r_key[1][63:32];
        init_words[5]  = SIGMA_1;
        init_words[6]  = r_nonce[31:0];
        init_words[7]  = r_nonce[63:32];
        init_words[8]  = r_counter[31:0];
        init_words[9]  = r_counter[63:32];
        init_words[10] = SIGMA_2;
        init_words[11] = r_key[2][31:0];
        init_words[12] = r_key[2][63:32];
        init_words[13] = r_key[3][31:0];
        init_words[14] = r_key[3][63:32];
        init_words[15] = SIGMA_3;
    end

    s20_core #(
        .ROUNDS (ROUNDS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_init  (init_words),
        .o_done  (core_done),
        .o_block (core_block)
    );

    assign new_rows = core_block;

    // A fresh block always starts at its first eight bytes.
    always_comb begin
        if (r_state == ST_GEN) begin
            src     = r_item;
            ks_row  = new_rows[0];
            cur_pos = 3'd0;
        end else begin
            src     = i_in_data;
            ks_row  = r_ks[r_pos];
            cur_pos = r_pos;
        end
        n_bytes  = src.bytes_in[3] ? FULL_BYTES : src.bytes_in;
        next_pos = cur_pos + 3'd1;
        for (int b = 0; b < 8; b++) begin
            result[8*b +: 8] = (n_bytes > 4'(b)) ?
                               (src.text_in[8*b +: 8] ^ ks_row[8*b +: 8]) : 8'd0;
        end
        out_write = ((r_state == ST_IDLE) && in_fire && !need_gen) ||
                    ((r_state == ST_GEN) && core_done);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (core_start) begin
                    n_state = ST_GEN;
                end
            end
            ST_GEN: begin
                if (core_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key       <= '{default: '0};
            r_nonce     <= '0;
            r_counter   <= '0;
            r_pos       <= '0;
            r_blk_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (out_write) begin
                r_out_valid <= 1'b1;
                if (n_bytes != 4'd0) begin
                    r_pos       <= next_pos;
                    r_blk_ready <= (next_pos != 3'd0);
                end
                if (src.message_end || (n_bytes != FULL_BYTES)) begin
                    r_pos       <= '0;
                    r_blk_ready <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (core_done) begin
                r_counter <= r_counter + 64'd1;
            end

            // Any key or nonce write restarts the keystream from block zero.
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_KEY_PART_0: r_key[0] <= i_cfg_data;
                    CFG_KEY_PART_1: r_key[1] <= i_cfg_data;
                    CFG_KEY_PART_2: r_key[2] <= i_cfg_data;
                    CFG_KEY_PART_3: r_key[3] <= i_cfg_data;
                    CFG_NONCE:      r_nonce  <= i_cfg_data;
                    default: begin
                    end
                endcase
                if (i_cfg_index <= CFG_NONCE) begin
                    r_counter   <= '0;
                    r_pos       <= '0;
                    r_blk_ready <= 1'b0;
                end
            end
        end

        if (core_start) begin
            r_item <= i_in_data;
        end
        if (core_done) begin
            r_ks <= new_rows;
        end
        if (out_write) begin
            r_out.text_out  <= result;
            r_out.bytes_out <= n_bytes;
        end
    end

endmodule

[rtl/s20_round.sv]
// One Salsa20 round: four quarter-rounds over columns or over rows.
module s20_round (
    input  s20_pkg::t_block i_words,
    input  logic            i_row_round,
    output s20_pkg::t_block o_words
);
    import s20_pkg::*;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_qr;

    localparam logic [3:0] COL_IDX [4][4] = '{
        '{4'd0,  4'd4,  4'd8,  4'd12},
        '{4'd5,  4'd9,  4'd13, 4'd1},
        '{4'd10, 4'd14, 4'd2,  4'd6},
        '{4'd15, 4'd3,  4'd7,  4'd11}
    };
    localparam logic [3:0] ROW_IDX [4][4] = '{
        '{4'd0,  4'd1,  4'd2,  4'd3},
        '{4'd5,  4'd6,  4'd7,  4'd4},
        '{4'd10, 4'd11, 4'd8,  4'd9},
        '{4'd15, 4'd12, 4'd13, 4'd14}
    };

    function automatic t_qr quarter(input t_word a, input t_word b,
                                    input t_word c, input t_word d);
        t_word x;
        t_qr   q;
        q.a = a;
        q.b = b;
        q.c = c;
        q.d = d;
        x   = q.a + q.d;
        q.b = q.b ^ {x[24:0], x[31:25]};
        x   = q.b + q.a;
        q.c = q.c ^ {x[22:0], x[31:23]};
        x   = q.c + q.b;
        q.d = q.d ^ {x[18:0], x[31:19]};
        x   = q.d + q.c;
        q.a = q.a ^ {x[13:0], x[31:14]};
        return q;
    endfunction

    t_block col_words;
    t_block row_words;
    t_qr    qc;
    t_qr    qr;

    always_comb begin
        col_words = i_words;
        row_words = i_words;
        qc = '0;
        qr = '0;
        for (int l = 0; l < 4; l++) begin
            qc = quarter(i_words[COL_IDX[l][0]], i_words[COL_IDX[l][1]],
                         i_words[COL_IDX[l][2]], i_words[COL_IDX[l][3]]);
            col_words[COL_IDX[l][0]] = qc.a;
            col_words[COL_IDX[l][1]] = qc.b;
            col_words[COL_IDX[l][2]] = qc.c;
            col_words[COL_IDX[l][3]] = qc.d;
            qr = quarter(i_words[ROW_IDX[l][0]], i_words[ROW_IDX[l][1]],
                         i_words[ROW_IDX[l][2]], i_words[ROW_IDX[l][3]]);
            row_words[ROW_IDX[l][0]] = qr.a;
            row_words[ROW_IDX[l][1]] = qr.b;
            row_words[ROW_IDX[l][2]] = qr.c;
            row_words[ROW_IDX[l][3]] = qr.d;
        end
        o_words = i_row_round ? row_words : col_words;
    end

endmodule

[rtl/s20_core.sv]
// Keystream block generator: one round per cycle through a shared round unit.
module s20_core #(
    parameter int unsigned ROUNDS = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  s20_pkg::t_block i_init,
    output logic            o_done,
    output s20_pkg::t_block o_block
);
    import s20_pkg::*;

    localparam int unsigned RND_W = $clog2(ROUNDS);

    t_core_state r_state, n_state;
    t_block      r_words, n_words;
    logic [RND_W-1:0] r_round, n_round;
    t_block      round_out;

    s20_round u_round (
        .i_words     (r_words),
        .i_row_round (r_round[0]),
        .o_words     (round_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
        r_words <= n_words;
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_words = r_words;
        o_done  = 1'b0;
        for (int i = 0; i < 16; i++) begin
            o_block[i] = r_words[i] + i_init[i];
        end
        case (r_state)
            CORE_IDLE: begin
                if (i_start) begin
                    n_words = i_init;
                    n_round = '0;
                    n_state = CORE_RUN;
                end
            end
            CORE_RUN: begin
                n_words = round_out;
                n_round = r_round + 1'b1;
                if (r_round == RND_W'(ROUNDS - 1)) begin
                    n_state = CORE_ADD;
                end
            end
            CORE_ADD: begin
                // Feed-forward sum is presented combinationally this cycle.
                o_done  = 1'b1;
                n_state = CORE_IDLE;
            end
            default: begin
                n_state = CORE_IDLE;
            end
        endcase
    end

endmodule

[tb/sv/salsa20_stream_cipher_checker.sv]
// Channel monitor with a Salsa20 keystream predictor and in-order result comparison.
`timescale 1ns / 1ps

module salsa20_stream_cipher_checker #(
    parameter int unsigned ROUNDS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  s20_pkg::t_in_item             i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  s20_pkg::t_out_item            i_out_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [s20_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import s20_pkg::*;

    logic [3:0][63:0] key_regs;
    logic [63:0]      nonce_reg;
    t_block           ks_words;
    logic [63:0]      block_ctr;
    logic [2:0]       slot;
    logic             block_valid;
    t_out_item        expected_q[$];
    int               fails = 0;

    function automatic t_word rotl(input t_word v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic t_block quarter_mix(input t_block w, input int a, input int b,
                                           input int c, input int d);
        w[b] = w[b] ^ rotl(w[a] + w[d], 7);
        w[c] = w[c] ^ rotl(w[b] + w[a], 9);
        w[d] = w[d] ^ rotl(w[c] + w[b], 13);
        w[a] = w[a] ^ rotl(w[d] + w[c], 18);
        return w;
    endfunction

    function automatic t_block salsa_block(input logic [3:0][63:0] keys,
                                           input logic [63:0] nonce_v,
                                           input logic [63:0] ctr);
        t_block init;
        t_block x;
        t_block sum;
        init[0]  = SIGMA_0;
        init[1]  = keys[0][31:0];
        init[2]  = keys[0][63:32];
        init[3]  = keys[1][31:0];
        init[4]  = keys[1][63:32];
        init[5]  = SIGMA_1;
        init[6]  = nonce_v[31:0];
        init[7]  = nonce_v[63:32];
        init[8]  = ctr[31:0];
        init[9]  = ctr[63:32];
        init[10] = SIGMA_2;
        init[11] = keys[2][31:0];
        init[12] = keys[2][63:32];
        init[13] = keys[3][31:0];
        init[14] = keys[3][63:32];
        init[15] = SIGMA_3;
        x = init;
        // Column rounds on even steps, row rounds on odd steps.
        for (int r = 0; r < ROUNDS; r++) begin
            if ((r % 2) == 0) begin
                x = quarter_mix(x, 0, 4, 8, 12);
                x = quarter_mix(x, 5, 9, 13, 1);
                x = quarter_mix(x, 10, 14, 2, 6);
                x = quarter_mix(x, 15, 3, 7, 11);
            end else begin
                x = quarter_mix(x, 0, 1, 2, 3);
                x = quarter_mix(x, 5, 6, 7, 4);
                x = quarter_mix(x, 10, 11, 8, 9);
                x = quarter_mix(x, 15, 12, 13, 14);
            end
        end
        for (int i = 0; i < 16; i++) begin
            sum[i] = x[i] + init[i];
        end
        return sum;
    endfunction

    task automatic clear_stream();
        ks_words    = '0;
        block_ctr   = '0;
        slot        = '0;
        block_valid = 1'b0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        case (idx)
            CFG_KEY_PART_0: key_regs[0] = value;
            CFG_KEY_PART_1: key_regs[1] = value;
            CFG_KEY_PART_2: key_regs[2] = value;
            CFG_KEY_PART_3: key_regs[3] = value;
            CFG_NONCE:      nonce_reg = value;
            default:        return;
        endcase
        clear_stream();
    endtask

    task automatic predict_chunk(input t_in_item chunk);
        logic [3:0]  nbytes;
        logic [63:0] stream;
        logic [63:0] mask;
        int          w_idx;
        t_out_item   want;
        nbytes = (chunk.bytes_in > FULL_BYTES) ? FULL_BYTES : chunk.bytes_in;
        want.text_out  = '0;
        want.bytes_out = nbytes;
        if (nbytes != 0) begin
            if (!block_valid) begin
                ks_words    = salsa_block(key_regs, nonce_reg, block_ctr);
                block_ctr   = block_ctr + 64'd1;
                block_valid = 1'b1;
                slot        = '0;
            end
            w_idx  = 2 * int'(slot);
            stream = {ks_words[w_idx + 1], ks_words[w_idx]};
            mask   = (nbytes == FULL_BYTES) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
            want.text_out = (chunk.text_in ^ stream) & mask;
            slot = slot + 3'd1;
            if (slot == 3'd0) begin
                block_valid = 1'b0;
            end
        end
        // A short chunk closes its message just like the end flag does.
        if (chunk.message_end || nbytes < FULL_BYTES) begin
            block_valid = 1'b0;
            slot        = '0;
        end
        expected_q.push_back(want);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: text_out %h, bytes_out %0d",
                   got.text_out, got.bytes_out);
            fails++;
            return;
        end
        want = expected_q.pop_front();
        if (got.text_out !== want.text_out) begin
            $error("text_out mismatch: expected %h, actual %h", want.text_out, got.text_out);
            fails++;
        end
        if (got.bytes_out !== want.bytes_out) begin
            $error("bytes_out mismatch: expected %0d, actual %0d",
                   want.bytes_out, got.bytes_out);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_regs  = '0;
            nonce_reg = '0;
            clear_stream();
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                predict_chunk(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/salsa20_stream_cipher_top_test.sv]
// Testbench top: clock, reset, chunk and register stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module salsa20_stream_cipher_top_test;
    import s20_pkg::*;

    localparam int unsigned ROUNDS         = 20;
    localparam int          PHASE_ITEMS    = 265;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_NONCE + 3'd1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   items_sent = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   hold_reqs = 0;
    int   hold_seen = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    salsa20_stream_cipher_top #(
        .ROUNDS(ROUNDS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    salsa20_stream_cipher_checker #(
        .ROUNDS(ROUNDS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat on any channel for %0d cycles", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Valid is left high after the beat; the next call drives a new chunk, or a drain lowers it.
    task automatic send_chunk(input logic [63:0] text, input logic [3:0] nbytes,
                              input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data.text_in     <= text;
        i_in_data.bytes_in    <= nbytes;
        i_in_data.message_end <= last;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_settings(input logic [3:0][63:0] keys, input logic [63:0] nonce_v);
        wait_drain();
        write_reg(CFG_KEY_PART_0, keys[0]);
        write_reg(CFG_KEY_PART_1, keys[1]);
        write_reg(CFG_KEY_PART_2, keys[2]);
        write_reg(CFG_KEY_PART_3, keys[3]);
        write_reg(CFG_NONCE, nonce_v);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly whole messages of full chunks, sometimes longer than one block,
    // with a little noise in the byte count and the end flag.
    task automatic send_message();
        int          len;
        logic [3:0]  nbytes;
        logic        last;
        len = ($urandom_range(3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            nbytes = FULL_BYTES;
            last   = (k == len - 1);
            if (last && $urandom_range(1) == 1) begin
                nbytes = 4'($urandom_range(1, 8));
            end
            if ($urandom_range(99) < 4) begin
                nbytes = 4'($urandom_range(15));
                last   = 1'($urandom_range(1));
            end
            send_chunk(pick_word(), nbytes, last);
        end
    endtask

    initial begin
        int phase_start;
        logic [3:0][63:0] keys;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_KEY_PART_0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key and nonce first, then the all-ones setting.
        send_chunk('0, FULL_BYTES, 1'b1);
        load_settings('1, '1);
        for (int b = 0; b < 9; b++) begin
            send_chunk(pick_word(), FULL_BYTES, 1'b0);
        end
        send_chunk('1, FULL_BYTES, 1'b1);
        for (int b = 1; b < 8; b++) begin
            send_chunk('1, 4'(b), 1'b0);
        end
        send_chunk(pick_word(), 4'd0, 1'b0);
        send_chunk(pick_word(), 4'd9, 1'b0);
        send_chunk('1, 4'd15, 1'b1);

        // A write to an unmapped index must leave the running block alone.
        for (int b = 0; b < 3; b++) begin
            send_chunk(pick_word(), FULL_BYTES, 1'b0);
        end
        wait_drain();
        write_reg(CFG_SPARE_IDX, '1);
        i_cfg_valid <= 1'b0;
        send_chunk(pick_word(), FULL_BYTES, 1'b1);

        load_settings('0, '0);
        send_chunk('0, FULL_BYTES, 1'b0);
        send_chunk('1, FULL_BYTES, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 59;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 59;
                end
                default: begin
                    send_idle_pct = 10;
                    stall_pct     = 10;
                end
            endcase
            keys = {pick_word(), pick_word(), pick_word(), pick_word()};
            load_settings(keys, pick_word());
            if (phase == 0) begin
                // Hold the output while chunks keep coming, so the input backs up.
                hold_reqs++;
                for (int b = 0; b < 48; b++) begin
                    send_chunk(pick_word(), FULL_BYTES, ($urandom_range(7) == 0));
                end
                wait_drain();
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_message();
            end
        end

        stall_pct = 0;
        wait_drain();
        repeat (ROUNDS + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
